### design/dds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dds_pkg
// Shared types and codes for the deadline disk head scheduler.
// ----------------------------------------------------------------------------
package dds_pkg;

    // per-cycle command to every cell of the request chain
    typedef struct packed {
        logic add;    // append new request at the first free cell
        logic hit;    // drop entries whose block equals the head
        logic shift;  // close holes: take the right neighbor's entry
        logic scan;   // pass the running best entry one cell right
    } t_cell_ctl;

    localparam logic        OP_TICK = 1'b0;
    localparam logic        OP_ADD  = 1'b1;

    localparam logic [1:0]  MOVE_NONE = 2'd0;
    localparam logic [1:0]  MOVE_UP   = 2'd1;
    localparam logic [1:0]  MOVE_DOWN = 2'd2;

    localparam int          CFG_DATA_W     = 32;
    localparam int          CFG_ADDR_W     = 3;
    localparam logic        REG_LAST_BLOCK = 1'b0;
    localparam int          LAST_BLOCK_W   = 16;
    localparam int          DIST_W         = 32;

endpackage

### design/dds_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dds_cell
// One slot of the request chain: entry storage, hole closing, best pass.
// ----------------------------------------------------------------------------
module dds_cell
    import dds_pkg::*;
#(
    parameter int BLOCK_BITS    = 16,
    parameter int DEADLINE_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cell_ctl                i_ctl,
    input  logic [BLOCK_BITS-1:0]    i_head,
    input  logic [BLOCK_BITS-1:0]    i_new_blk,
    input  logic [DEADLINE_BITS-1:0] i_new_dl,
    input  logic                     i_prev_valid,
    input  logic                     i_hole_in,
    input  logic                     i_nxt_valid,
    input  logic [BLOCK_BITS-1:0]    i_nxt_blk,
    input  logic [DEADLINE_BITS-1:0] i_nxt_dl,
    input  logic                     i_best_in_v,
    input  logic [BLOCK_BITS-1:0]    i_best_in_blk,
    input  logic [DEADLINE_BITS-1:0] i_best_in_dl,
    output logic                     o_valid,
    output logic [BLOCK_BITS-1:0]    o_blk,
    output logic [DEADLINE_BITS-1:0] o_dl,
    output logic                     o_hole_out,
    output logic                     o_hit,
    output logic                     o_best_v,
    output logic [BLOCK_BITS-1:0]    o_best_blk,
    output logic [DEADLINE_BITS-1:0] o_best_dl
);

    logic                     r_valid, n_valid;
    logic [BLOCK_BITS-1:0]    r_blk, n_blk;
    logic [DEADLINE_BITS-1:0] r_dl, n_dl;
    logic                     r_best_v, n_best_v;
    logic [BLOCK_BITS-1:0]    r_best_blk, n_best_blk;
    logic [DEADLINE_BITS-1:0] r_best_dl, n_best_dl;
    logic                     w_take;

    assign o_hit      = r_valid && (r_blk == i_head);
    assign o_hole_out = i_hole_in | ~r_valid;
    // strict compare: an earlier cell (older item) wins ties
    assign w_take     = r_valid && (!i_best_in_v || (r_dl < i_best_in_dl));

    always_comb begin
        n_valid    = r_valid;
        n_blk      = r_blk;
        n_dl       = r_dl;
        n_best_v   = r_best_v;
        n_best_blk = r_best_blk;
        n_best_dl  = r_best_dl;
        if (i_ctl.add && !r_valid && i_prev_valid) begin
            n_valid = 1'b1;
            n_blk   = i_new_blk;
            n_dl    = i_new_dl;
        end
        if (i_ctl.hit && o_hit) begin
            n_valid = 1'b0;
        end
        if (i_ctl.shift && o_hole_out) begin
            n_valid = i_nxt_valid;
            n_blk   = i_nxt_blk;
            n_dl    = i_nxt_dl;
        end
        if (i_ctl.scan) begin
            n_best_v   = w_take | i_best_in_v;
            n_best_blk = w_take ? r_blk : i_best_in_blk;
            n_best_dl  = w_take ? r_dl  : i_best_in_dl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_blk      <= n_blk;
        r_dl       <= n_dl;
        r_best_v   <= n_best_v;
        r_best_blk <= n_best_blk;
        r_best_dl  <= n_best_dl;
    end

    assign o_valid    = r_valid;
    assign o_blk      = r_blk;
    assign o_dl       = r_dl;
    assign o_best_v   = r_best_v;
    assign o_best_blk = r_best_blk;
    assign o_best_dl  = r_best_dl;

endmodule

### design/deadline_disk_head_scheduler.sv
`timescale 1ns / 1ps
// Sequence: an add item goes from acceptance straight to S_OUT, where the result
// registers load; a tick item passes S_COMPACT for H (0..QUEUE_DEPTH-1) hole-closing
// steps after served entries drop, S_SCAN (best-deadline pass, one cell per cycle),
// S_MOVE and S_OUT. One item in flight; the next is accepted once the result is registered.
// Reset (synchronous, active low) empties the table, zeroes head and distance,
// and sets last_block to 65535.
// ----------------------------------------------------------------------------
// deadline_disk_head_scheduler
// Deadline-first disk head scheduler built on a chain of request cells.
// ----------------------------------------------------------------------------
module deadline_disk_head_scheduler
    import dds_pkg::*;
#(
    parameter int QUEUE_DEPTH   = 16,
    parameter int BLOCK_BITS    = 16,
    parameter int DEADLINE_BITS = 16,
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // APB configuration port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_W-1:0]    paddr,
    input  logic [CFG_DATA_W-1:0]    pwdata,
    output logic [CFG_DATA_W-1:0]    prdata,
    output logic                     pready,
    // input item channel
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic                     i_operation,
    input  logic [BLOCK_BITS-1:0]    i_request_block,
    input  logic [DEADLINE_BITS-1:0] i_request_deadline,
    // result item channel
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [BLOCK_BITS-1:0]    o_head_position,
    output logic [CNT_W-1:0]         o_served_count,
    output logic [1:0]               o_head_move,
    output logic [DIST_W-1:0]        o_total_distance,
    output logic [CNT_W-1:0]         o_pending_count,
    output logic                     o_rejected
);

    localparam int D    = QUEUE_DEPTH;
    localparam int SC_W = $clog2(QUEUE_DEPTH);
    localparam int CMP_W = (BLOCK_BITS > LAST_BLOCK_W) ? BLOCK_BITS : LAST_BLOCK_W;

    // sequencer codes
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_COMPACT = 3'd1;
    localparam logic [2:0] S_SCAN    = 3'd2;
    localparam logic [2:0] S_MOVE    = 3'd3;
    localparam logic [2:0] S_OUT     = 3'd4;

    logic [2:0]               r_state, n_state;
    logic [SC_W-1:0]          r_scan, n_scan;
    logic [LAST_BLOCK_W-1:0]  r_last;
    logic [BLOCK_BITS-1:0]    r_head, n_head;
    logic [DIST_W-1:0]        r_dist, n_dist;
    logic [CNT_W-1:0]         r_count, n_count;
    logic [CNT_W-1:0]         r_served, n_served;
    logic [1:0]               r_move, n_move;
    logic                     r_rej, n_rej;
    logic                     r_ov;
    logic [BLOCK_BITS-1:0]    r_o_head;
    logic [CNT_W-1:0]         r_o_served, r_o_pend;
    logic [1:0]               r_o_move;
    logic [DIST_W-1:0]        r_o_dist;
    logic                     r_o_rej;

    t_cell_ctl                w_ctl;
    logic                     w_accept, w_load_out, w_gap, w_reject;
    logic [CNT_W-1:0]         w_hits;

    // chain wiring
    logic                     w_valid    [D];
    logic [BLOCK_BITS-1:0]    w_blk      [D];
    logic [DEADLINE_BITS-1:0] w_dl       [D];
    logic                     w_hole     [D];
    logic                     w_hit      [D];
    logic                     w_best_v   [D];
    logic [BLOCK_BITS-1:0]    w_best_blk [D];
    logic [DEADLINE_BITS-1:0] w_best_dl  [D];

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= {LAST_BLOCK_W{1'b1}};
        end else if (psel && penable && pwrite && (paddr[2] == REG_LAST_BLOCK)) begin
            r_last <= pwdata[LAST_BLOCK_W-1:0];
        end
    end
    assign prdata = (paddr[2] == REG_LAST_BLOCK)
                  ? {{(CFG_DATA_W-LAST_BLOCK_W){1'b0}}, r_last} : '0;

    // ---------------- handshake ----------------
    assign o_ready    = (r_state == S_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign w_load_out = (r_state == S_OUT) && (!r_ov || i_ready);

    // add is refused when full or when the block is past the drive end
    assign w_reject = (r_count == CNT_W'(D)) ||
                      (CMP_W'(i_request_block) > CMP_W'(r_last));

    // ---------------- cell chain ----------------
    always_comb begin
        w_ctl       = '0;
        w_ctl.add   = w_accept && (i_operation == OP_ADD) && !w_reject;
        w_ctl.hit   = w_accept && (i_operation == OP_TICK);
        w_ctl.shift = (r_state == S_COMPACT) && w_gap;
        w_ctl.scan  = (r_state == S_SCAN);
    end

    for (genvar g = 0; g < D; g++) begin : g_cell
        dds_cell #(
            .BLOCK_BITS    (BLOCK_BITS),
            .DEADLINE_BITS (DEADLINE_BITS)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_head        (r_head),
            .i_new_blk     (i_request_block),
            .i_new_dl      (i_request_deadline),
            .i_prev_valid  ((g == 0) ? 1'b1 : w_valid[(g == 0) ? 0 : g-1]),
            .i_hole_in     ((g == 0) ? 1'b0 : w_hole[(g == 0) ? 0 : g-1]),
            .i_nxt_valid   ((g == D-1) ? 1'b0 : w_valid[(g == D-1) ? g : g+1]),
            .i_nxt_blk     ((g == D-1) ? '0 : w_blk[(g == D-1) ? g : g+1]),
            .i_nxt_dl      ((g == D-1) ? '0 : w_dl[(g == D-1) ? g : g+1]),
            .i_best_in_v   ((g == 0) ? 1'b0 : w_best_v[(g == 0) ? 0 : g-1]),
            .i_best_in_blk ((g == 0) ? '0 : w_best_blk[(g == 0) ? 0 : g-1]),
            .i_best_in_dl  ((g == 0) ? '0 : w_best_dl[(g == 0) ? 0 : g-1]),
            .o_valid       (w_valid[g]),
            .o_blk         (w_blk[g]),
            .o_dl          (w_dl[g]),
            .o_hole_out    (w_hole[g]),
            .o_hit         (w_hit[g]),
            .o_best_v      (w_best_v[g]),
            .o_best_blk    (w_best_blk[g]),
            .o_best_dl     (w_best_dl[g])
        );
    end

    // served count and hole detection over the chain
    always_comb begin
        w_hits = '0;
        w_gap  = 1'b0;
        for (int i = 0; i < D; i++) begin
            w_hits = w_hits + CNT_W'(w_hit[i]);
        end
        for (int i = 0; i < D-1; i++) begin
            w_gap = w_gap | (!w_valid[i] && w_valid[i+1]);
        end
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state  = r_state;
        n_scan   = r_scan;
        n_head   = r_head;
        n_dist   = r_dist;
        n_count  = r_count;
        n_served = r_served;
        n_move   = r_move;
        n_rej    = r_rej;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_move = MOVE_NONE;
                    if (i_operation == OP_ADD) begin
                        n_served = '0;
                        n_rej    = w_reject;
                        n_count  = w_reject ? r_count : r_count + CNT_W'(1);
                        n_state  = S_OUT;
                    end else begin
                        n_served = w_hits;
                        n_rej    = 1'b0;
                        n_count  = r_count - w_hits;
                        n_state  = S_COMPACT;
                    end
                end
            end
            S_COMPACT: begin
                if (!w_gap) begin
                    n_scan  = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                n_scan = r_scan + SC_W'(1);
                if (r_scan == SC_W'(D-1)) begin
                    n_state = S_MOVE;
                end
            end
            S_MOVE: begin
                if (w_best_v[D-1]) begin
                    if (w_best_blk[D-1] > r_head) begin
                        n_head = r_head + BLOCK_BITS'(1);
                        n_move = MOVE_UP;
                    end else if (w_best_blk[D-1] < r_head) begin
                        n_head = r_head - BLOCK_BITS'(1);
                        n_move = MOVE_DOWN;
                    end
                    if ((w_best_blk[D-1] != r_head) && (r_dist != {DIST_W{1'b1}})) begin
                        n_dist = r_dist + DIST_W'(1);
                    end
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_dist  <= '0;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_dist  <= n_dist;
            r_count <= n_count;
            if (w_load_out) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
        r_scan   <= n_scan;
        r_served <= n_served;
        r_move   <= n_move;
        r_rej    <= n_rej;
        if (w_load_out) begin
            r_o_head   <= r_head;
            r_o_served <= r_served;
            r_o_move   <= r_move;
            r_o_dist   <= r_dist;
            r_o_pend   <= r_count;
            r_o_rej    <= r_rej;
        end
    end

    assign o_valid          = r_ov;
    assign o_head_position  = r_o_head;
    assign o_served_count   = r_o_served;
    assign o_head_move      = r_o_move;
    assign o_total_distance = r_o_dist;
    assign o_pending_count  = r_o_pend;
    assign o_rejected       = r_o_rej;

endmodule

### design/dds_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dds_checker
// Port-level checks for the deadline disk head scheduler.
// ----------------------------------------------------------------------------
module dds_checker
    import dds_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int BLOCK_BITS  = 16,
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_valid,
    input logic                  i_ready,
    input logic [BLOCK_BITS-1:0] o_head_position,
    input logic [CNT_W-1:0]      o_served_count,
    input logic [1:0]            o_head_move,
    input logic [CNT_W-1:0]      o_pending_count,
    input logic                  o_rejected
);

    a_rej_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rejected |-> (o_served_count == '0) && (o_head_move == MOVE_NONE))
        else $error("rejected add shows service or motion");

    a_pend_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pending_count + o_served_count) <= CNT_W'(QUEUE_DEPTH))
        else $error("pending plus served exceeds table depth");

    a_move_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_head_move == MOVE_NONE) || (o_head_move == MOVE_UP)
                 || (o_head_move == MOVE_DOWN))
        else $error("bad head move code");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_head_position))
        else $error("result dropped or changed while stalled");

endmodule

bind deadline_disk_head_scheduler dds_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .BLOCK_BITS  (BLOCK_BITS)
) u_dds_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_head_position (o_head_position),
    .o_served_count  (o_served_count),
    .o_head_move     (o_head_move),
    .o_pending_count (o_pending_count),
    .o_rejected      (o_rejected)
);

### tb/deadline_disk_head_scheduler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadline_disk_head_scheduler_tb
// Self-checking bench for the deadline disk head scheduler. A behavioral
// request table follows every accepted item and predicts its result, which
// is compared field by field with what the block returns. Directed items
// cover empty ticks, multi-serve, ties, rejects and both head directions.
// Random items are biased near the head so requests are served. The bench
// steps through last_block settings and idle/stall mixes.
// ----------------------------------------------------------------------------
module deadline_disk_head_scheduler_tb;
    import dds_pkg::*;

    localparam int DEPTH       = 16;
    localparam int CYCLE_LIMIT = 1500000;

    typedef struct packed {
        logic [15:0] head;
        logic [4:0]  served;
        logic [1:0]  move;
        logic [31:0] distance;
        logic [4:0]  pending;
        logic        rej;
    } t_sched_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic                  i_operation = OP_TICK;
    logic [15:0]           i_request_block = '0;
    logic [15:0]           i_request_deadline = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [15:0]           o_head_position;
    logic [4:0]            o_served_count;
    logic [1:0]            o_head_move;
    logic [31:0]           o_total_distance;
    logic [4:0]            o_pending_count;
    logic                  o_rejected;

    deadline_disk_head_scheduler u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_valid(i_valid), .o_ready(o_ready), .i_operation(i_operation),
        .i_request_block(i_request_block), .i_request_deadline(i_request_deadline),
        .o_valid(o_valid), .i_ready(i_ready), .o_head_position(o_head_position),
        .o_served_count(o_served_count), .o_head_move(o_head_move),
        .o_total_distance(o_total_distance), .o_pending_count(o_pending_count),
        .o_rejected(o_rejected)
    );

    always #2 i_clk = ~i_clk;

    // Shadow of the request table
    logic [15:0] tbl_block [DEPTH];
    logic [15:0] tbl_deadline [DEPTH];
    logic        tbl_valid [DEPTH];
    int          tbl_age [DEPTH];
    logic [15:0] sh_head;
    logic [31:0] sh_dist;
    logic [15:0] sh_last_block;

    t_sched_result pending_results [$];

    int send_gap_pct;
    int stall_pct;
    int errors;
    int cycles;
    int n_items, n_results, n_rejects, n_moves, max_served;

    // Next result of the table for one item; updates the shadow state.
    function automatic t_sched_result schedule_step(logic op, logic [15:0] blk,
                                                    logic [15:0] dl);
        t_sched_result r;
        logic hit [DEPTH];
        int slot, n, best, older;
        r = '0;
        slot = -1;
        n = 0;
        best = -1;
        for (int i = 0; i < DEPTH; i++) if (tbl_valid[i]) n++;
        if (op == OP_ADD) begin
            for (int i = DEPTH - 1; i >= 0; i--) if (!tbl_valid[i]) slot = i;
            if (slot < 0 || blk > sh_last_block) begin
                r.rej = 1'b1;
            end else begin
                tbl_block[slot] = blk;
                tbl_deadline[slot] = dl;
                tbl_age[slot] = n;
                tbl_valid[slot] = 1'b1;
            end
        end else begin
            for (int i = 0; i < DEPTH; i++) begin
                hit[i] = tbl_valid[i] && tbl_block[i] == sh_head;
                if (hit[i]) r.served++;
            end
            // survivors keep a dense arrival rank
            for (int i = 0; i < DEPTH; i++) begin
                if (tbl_valid[i] && !hit[i]) begin
                    older = 0;
                    for (int j = 0; j < DEPTH; j++)
                        if (hit[j] && tbl_age[j] < tbl_age[i]) older++;
                    tbl_age[i] -= older;
                end
            end
            for (int i = 0; i < DEPTH; i++) if (hit[i]) tbl_valid[i] = 1'b0;
            for (int i = 0; i < DEPTH; i++) begin
                if (tbl_valid[i] && (best < 0 || tbl_deadline[i] < tbl_deadline[best] ||
                    (tbl_deadline[i] == tbl_deadline[best] && tbl_age[i] < tbl_age[best])))
                    best = i;
            end
            r.move = MOVE_NONE;
            if (best >= 0) begin
                if (tbl_block[best] > sh_head) begin
                    sh_head++;
                    r.move = MOVE_UP;
                end else if (tbl_block[best] < sh_head) begin
                    sh_head--;
                    r.move = MOVE_DOWN;
                end
                if (r.move != MOVE_NONE && sh_dist != 32'hFFFF_FFFF) sh_dist++;
            end
        end
        n = 0;
        for (int i = 0; i < DEPTH; i++) if (tbl_valid[i]) n++;
        r.head = sh_head;
        r.distance = sh_dist;
        r.pending = n[4:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d (cycle %0d)", what, got, want, cycles);
        errors++;
    endtask

    // Send one item; called at a rising edge, returns at the accepting edge.
    task automatic send_item(logic op, logic [15:0] blk, logic [15:0] dl);
        t_sched_result r;
        if ($urandom_range(99) < send_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_gap_pct) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= op;
        i_request_block <= blk;
        i_request_deadline <= dl;
        do @(posedge i_clk); while (!o_ready);
        r = schedule_step(op, blk, dl);
        pending_results = {pending_results, r};
        n_items++;
        if (r.rej) n_rejects++;
        if (r.move != MOVE_NONE) n_moves++;
        if (r.served > max_served) max_served = r.served;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_last_block(logic [15:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CFG_ADDR_W'(4 * REG_LAST_BLOCK);
        pwdata <= CFG_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sh_last_block = value;
    endtask

    // Result checker: oldest expectation against each accepted result
    always @(posedge i_clk) begin
        t_sched_result e;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("deadline_disk_head_scheduler_tb failed");
            $finish;
        end
        if (i_rst_n && o_valid && i_ready) begin
            n_results++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                e = pending_results.pop_front();
                if (o_head_position !== e.head)
                    report_mismatch("head_position", o_head_position, e.head);
                if (o_served_count !== e.served)
                    report_mismatch("served_count", o_served_count, e.served);
                if (o_head_move !== e.move)
                    report_mismatch("head_move", o_head_move, e.move);
                if (o_total_distance !== e.distance)
                    report_mismatch("total_distance", o_total_distance, e.distance);
                if (o_pending_count !== e.pending)
                    report_mismatch("pending_count", o_pending_count, e.pending);
                if (o_rejected !== e.rej)
                    report_mismatch("rejected", o_rejected, e.rej);
            end
        end
    end

    // Receiver: stall at the phase's rate
    always @(posedge i_clk) i_ready <= ($urandom_range(99) >= stall_pct);

    // Empty-table ticks, multi-serve at the head, tie on deadline, upward
    // and downward moves, out-of-range add at both extremes of last_block.
    task automatic test_directed();
        send_item(OP_TICK, 16'd0, 16'd0);        // empty table: no move
        send_item(OP_ADD, 16'd0, 16'hFFFF);
        send_item(OP_ADD, 16'd0, 16'd0);
        send_item(OP_ADD, 16'd0, 16'd9);
        send_item(OP_TICK, 16'd0, 16'd0);        // three served, table empties
        send_item(OP_ADD, 16'd3, 16'd5);
        send_item(OP_ADD, 16'd1, 16'd5);         // same deadline, later arrival
        send_item(OP_ADD, 16'd2, 16'd7);
        repeat (4) send_item(OP_TICK, 16'd0, 16'd0);
        send_item(OP_ADD, 16'd0, 16'd1);         // head must come back down
        repeat (4) send_item(OP_TICK, 16'd0, 16'd0);
        wait_drained();
        write_last_block(16'd0);
        send_item(OP_ADD, 16'd1, 16'd0);         // beyond last block
        send_item(OP_ADD, 16'hFFFF, 16'hFFFF);
        wait_drained();
        write_last_block(16'hFFFE);
        send_item(OP_ADD, 16'hFFFF, 16'd0);      // one past the last block
        wait_drained();
        write_last_block(16'hFFFF);
        send_item(OP_TICK, 16'd0, 16'd0);
        wait_drained();
    endtask

    // Random mix, mostly requests close to the head so they get served
    task automatic test_random(int count, int add_pct, logic [15:0] last_blk);
        logic [15:0] blk, dl;
        int off;
        wait_drained();
        write_last_block(last_blk);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(99) < add_pct) begin
                if ($urandom_range(99) < 80) begin
                    off = int'(sh_head) + $urandom_range(8) - 4;
                    if (off < 0) off = 0;
                    if (off > 65535) off = 65535;
                    blk = off[15:0];
                end else begin
                    blk = $urandom_range(65535);
                end
                dl = ($urandom_range(1)) ? 16'($urandom_range(7)) : 16'($urandom_range(65535));
                send_item(OP_ADD, blk, dl);
            end else begin
                send_item(OP_TICK, 16'($urandom_range(65535)), 16'($urandom_range(65535)));
            end
        end
    endtask

    initial begin
        int gaps [4] = '{0, 51, 0, 31};
        int stalls [4] = '{0, 0, 51, 31};
        send_gap_pct = 0;
        stall_pct = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        sh_head = '0;
        sh_dist = '0;
        sh_last_block = 16'hFFFF;
        for (int i = 0; i < DEPTH; i++) tbl_valid[i] = 1'b0;

        test_directed();
        for (int p = 0; p < 4; p++) begin
            send_gap_pct = gaps[p];
            stall_pct = stalls[p];
            test_random(240, 65, (p == 2) ? 16'd0 : 16'hFFFF);
            test_random(240, 45, (p == 2) ? 16'hFFFF : 16'($urandom_range(20, 400)));
        end
        wait_drained();

        $display("covered %0d items, %0d results, %0d rejected adds, %0d head moves",
                 n_items, n_results, n_rejects, n_moves);
        $display("most served on one tick: %0d, final distance %0d", max_served, sh_dist);
        if (errors == 0) begin
            $display("deadline_disk_head_scheduler_tb passed");
        end else begin
            $display("deadline_disk_head_scheduler_tb failed");
        end
        $finish;
    end

endmodule
